>>> rtl/sensor_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Sensor packet deframer assertion macros
// Shared check macros for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_DEFRAMER_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, masked during reset
`define SPD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SPD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Frame constants, widths and status codes.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int PAYLOAD_WORDS = 10;
  localparam int GROUP_BYTES   = 5;
  localparam int FRAME_BYTES   = GROUP_BYTES * PAYLOAD_WORDS;
  localparam int IDX_W         = $clog2(PAYLOAD_WORDS);
  localparam int GRP_W         = $clog2(PAYLOAD_WORDS + 1);
  localparam int ADDR_W        = IDX_W + 1;
  localparam int MEM_DEPTH     = 2 ** ADDR_W;

  localparam logic [7:0] HDR_A    = 8'd205;
  localparam logic [7:0] HDR_B    = 8'd235;
  localparam logic [7:0] HDR_C    = 8'd215;
  localparam logic [7:0] SEP_BYTE = 8'd32;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_SEP_ERR = 1'b1
  } frame_status_t;

endpackage

>>> rtl/sensor_packet_deframer.sv
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Finds 205 235 215 headers in a byte stream, collects a 50-byte payload and
// emits ten 32-bit words or one separator error result.
// ----------------------------------------------------------------------------
// One byte is taken every cycle. Payload words are assembled in a register
// and written into a two-bank word memory; an error-free frame flips the
// write bank, and its words are read back one per cycle while out_ready is
// high (one memory read port, registered read data, then an output register)
// while the next frame fills the other bank. The input stalls only on a byte
// that would complete a full frame during readout of the previous one.
`include "sensor_packet_deframer_defines.svh"

module sensor_packet_deframer
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  word_index,
  output logic [31:0] word_value,
  output logic        frame_status,
  output logic        last_result
);

  // frame parser state
  logic [7:0]       hist_older, hist_older_next;
  logic [7:0]       hist_newer, hist_newer_next;
  logic             length_next, length_next_next;
  logic [7:0]       target_len, target_len_next;
  logic [7:0]       rx_count, rx_count_next;
  logic [GRP_W-1:0] grp, grp_next;
  logic [2:0]       off, off_next;
  logic [23:0]      acc, acc_next;
  logic             sep_good, sep_good_next;
  logic             wbank, wbank_next;

  // readout state
  logic             drain_busy;
  logic             drain_err;
  logic             drain_bank;
  logic [IDX_W-1:0] drain_idx;
  logic             p_valid;
  logic [IDX_W-1:0] p_idx;
  logic             p_last;
  logic             p_err;
  logic [31:0]      rdata;

  logic [31:0]      mem [MEM_DEPTH];

  logic              fire;
  logic              hdr;
  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic              start;
  logic              start_err;
  logic              load;
  logic              issue;

  assign fire = in_valid && in_ready;
  assign hdr  = (hist_older == HDR_A) && (hist_newer == HDR_B) && (rx_byte == HDR_C);

  assign in_ready = !(drain_busy && !length_next && (target_len == 8'(FRAME_BYTES)) &&
                      (rx_count == 8'(FRAME_BYTES - 1)));

  always_comb begin
    hist_older_next  = hist_older;
    hist_newer_next  = hist_newer;
    length_next_next = length_next;
    target_len_next  = target_len;
    rx_count_next    = rx_count;
    grp_next         = grp;
    off_next         = off;
    acc_next         = acc;
    sep_good_next    = sep_good;
    wbank_next       = wbank;
    mem_we           = 1'b0;
    waddr            = {wbank, grp[IDX_W-1:0]};
    wdata            = {rx_byte, acc};
    start            = 1'b0;
    start_err        = 1'b0;
    if (fire) begin
      hist_older_next = hist_newer;
      hist_newer_next = rx_byte;
      if (hdr) begin
        length_next_next = 1'b1;
        target_len_next  = '0;
        rx_count_next    = '0;
        grp_next         = '0;
        off_next         = '0;
        sep_good_next    = 1'b1;
      end else if (length_next) begin
        target_len_next  = rx_byte;
        length_next_next = 1'b0;
      end else if (rx_count < target_len) begin
        if (grp < GRP_W'(PAYLOAD_WORDS)) begin
          case (off)
            3'd0: acc_next[7:0]   = rx_byte;
            3'd1: acc_next[15:8]  = rx_byte;
            3'd2: acc_next[23:16] = rx_byte;
            3'd3: mem_we          = 1'b1;
            default: begin
              if ((grp < GRP_W'(PAYLOAD_WORDS - 1)) && (rx_byte != SEP_BYTE)) begin
                sep_good_next = 1'b0;
              end
            end
          endcase
        end
        if (off == 3'(GROUP_BYTES - 1)) begin
          off_next = '0;
          if (grp < GRP_W'(PAYLOAD_WORDS)) begin
            grp_next = grp + 1'b1;
          end
        end else begin
          off_next = off + 1'b1;
        end
        rx_count_next = rx_count + 1'b1;
        if (rx_count_next == target_len) begin
          if (target_len == 8'(FRAME_BYTES)) begin
            start     = 1'b1;
            start_err = !sep_good_next;
            if (sep_good_next) begin
              wbank_next = !wbank;
            end
          end
          target_len_next = '0;
          rx_count_next   = '0;
          grp_next        = '0;
          off_next        = '0;
          sep_good_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_older  <= '0;
      hist_newer  <= '0;
      length_next <= 1'b0;
      target_len  <= '0;
      rx_count    <= '0;
      grp         <= '0;
      off         <= '0;
      sep_good    <= 1'b1;
      wbank       <= 1'b0;
    end else begin
      hist_older  <= hist_older_next;
      hist_newer  <= hist_newer_next;
      length_next <= length_next_next;
      target_len  <= target_len_next;
      rx_count    <= rx_count_next;
      grp         <= grp_next;
      off         <= off_next;
      sep_good    <= sep_good_next;
      wbank       <= wbank_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // readout: memory read -> p stage -> output register
  assign load  = p_valid && (!out_valid || out_ready);
  assign issue = drain_busy && (!p_valid || load);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata <= mem[{drain_bank, drain_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_busy <= 1'b0;
      drain_err  <= 1'b0;
      drain_bank <= 1'b0;
      drain_idx  <= '0;
      p_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (start) begin
        drain_busy <= 1'b1;
        drain_err  <= start_err;
        drain_bank <= wbank;
        drain_idx  <= '0;
      end else if (issue) begin
        drain_idx <= drain_idx + 1'b1;
        if (drain_err || (drain_idx == IDX_W'(PAYLOAD_WORDS - 1))) begin
          drain_busy <= 1'b0;
        end
      end
      if (issue) begin
        p_valid <= 1'b1;
      end else if (load) begin
        p_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx  <= drain_idx;
      p_err  <= drain_err;
      p_last <= drain_err || (drain_idx == IDX_W'(PAYLOAD_WORDS - 1));
    end
    if (load) begin
      word_index   <= p_err ? 4'd0 : 4'(p_idx);
      word_value   <= p_err ? 32'd0 : rdata;
      frame_status <= p_err ? STATUS_SEP_ERR : STATUS_OK;
      last_result  <= p_last;
    end
  end

  `SPD_CHECK(a_start_idle, start, !drain_busy, "frame completed during readout")
  `SPD_CHECK(a_bank_split, drain_busy && !drain_err, drain_bank != wbank,
             "readout bank is being written")
  `SPD_CHECK(a_err_result, out_valid && (frame_status == STATUS_SEP_ERR),
             last_result && (word_value == 32'd0), "malformed error result")
  `SPD_CHECK_NEXT(a_issue_fills, issue, p_valid, "read issued without stage fill")

endmodule
